// File: hw/rtl/lz4d_pkg.sv
// Package: shared types and constants for the LZ4 block decompressor.
`timescale 1ns / 1ps
`default_nettype none
package lz4d_pkg;
  localparam int unsigned WindowBytes = 65536;
  localparam int unsigned MinMatch = 4;
  localparam int unsigned MlBits = 4;
  localparam logic [3:0] NibMax = 4'hF;
  localparam logic [7:0] ExtMore = 8'hFF;

  localparam logic [3:0] ERR_OK = 4'd0;
  localparam logic [3:0] ERR_LITLEN = 4'd1;
  localparam logic [3:0] ERR_LITOVR = 4'd2;
  localparam logic [3:0] ERR_ZEROOFF = 4'd3;
  localparam logic [3:0] ERR_MLTRUNC = 4'd4;
  localparam logic [3:0] ERR_OFFSTART = 4'd5;
  localparam logic [3:0] ERR_OVERFLOW = 4'd6;
  localparam logic [3:0] ERR_OFFTRUNC = 4'd7;
  localparam logic [3:0] ERR_DURMATCH = 4'd8;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic        byte_valid;
    logic [7:0]  out_byte;
    logic        match_pending;
    logic        done_res;
    logic [3:0]  error_code;
    logic [31:0] decoded_length;
  } out_item_t;

  // Work command from the parser to the execution stage.
  typedef struct packed {
    logic        emit;       // produce a result
    logic        from_hist;  // byte comes from history
    logic [7:0]  lit_byte;
    logic [15:0] src_addr;
    logic [15:0] wr_addr;
    logic        byte_valid;
    logic        match_pending;
    logic        done_res;
    logic [3:0]  error_code;
    logic [31:0] decoded_length;
  } cmd_t;
endpackage
`default_nettype wire

// File: hw/rtl/lz4d_ram.sv
// Generic single-write, single-read RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module lz4d_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: hw/rtl/lz4d_front.sv
// Front end: parses tokens and lengths, issues at most one command per transaction.
`timescale 1ns / 1ps
`default_nettype none
module lz4d_front
  import lz4d_pkg::*;
#(
  parameter int unsigned WINDOW_BYTES = WindowBytes
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [31:0] max_output_size,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_item,
  output logic             cmd_valid,
  input  wire logic        cmd_ready,
  output cmd_t             cmd
);
  localparam int unsigned AW = $clog2(WINDOW_BYTES);

  typedef enum logic [6:0] {
    PH_TOKEN  = 7'b0000001,
    PH_LITEXT = 7'b0000010,
    PH_LIT    = 7'b0000100,
    PH_OFFLO  = 7'b0001000,
    PH_OFFHI  = 7'b0010000,
    PH_MLEXT  = 7'b0100000,
    PH_MATCH  = 7'b1000000
  } phase_t;

  phase_t      phase, phase_next;
  logic [3:0]  match_nibble, match_nibble_next;
  logic [31:0] remaining, remaining_next;
  logic [15:0] offset_value, offset_value_next;
  logic [31:0] produced, produced_next;
  logic        seen_last, seen_last_next;
  logic        discarding, discarding_next;
  cmd_t        c;

  // Length guards and saturating sums, evaluated per transaction.
  logic [32:0] lit_sum, ml_sum;
  logic [31:0] rem_in, sat_rem, sat_rem4;
  logic        end_blk, fail;
  logic [3:0]  fcode;
  logic        ext_more;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  assign in_ready = !cmd_valid || cmd_ready;
  wire fire = in_valid && in_ready;
  wire k = in_item.kind;
  wire [7:0] b = in_item.data_byte;
  wire lst = in_item.last;

  always_comb begin
    phase_next = phase;
    match_nibble_next = match_nibble;
    remaining_next = remaining;
    offset_value_next = offset_value;
    produced_next = produced;
    seen_last_next = seen_last;
    discarding_next = discarding;
    end_blk = 1'b0;
    fail = 1'b0;
    fcode = ERR_OK;
    ext_more = (b == ExtMore);
    rem_in = remaining;
    sat_rem = 32'd0;
    sat_rem4 = 32'd0;
    lit_sum = 33'd0;
    ml_sum = 33'd0;
    c = '0;
    if (discarding) begin
      if (!k && lst) discarding_next = 1'b0;
    end else if (k) begin
      if (phase == PH_MATCH) begin
        c.emit = 1'b1;
        c.from_hist = 1'b1;
        c.src_addr = AW'(produced - 32'(offset_value));
        c.wr_addr = AW'(produced);
        c.byte_valid = 1'b1;
        produced_next = produced + 32'd1;
        remaining_next = remaining - 32'd1;
        if (remaining_next != 32'd0) c.match_pending = 1'b1;
        else if (seen_last) end_blk = 1'b1;
        else phase_next = PH_TOKEN;
        c.decoded_length = produced_next;
      end
    end else begin
      case (phase)
        PH_TOKEN, PH_LITEXT: begin
          if (phase == PH_TOKEN) begin
            match_nibble_next = b[3:0];
            sat_rem = {28'd0, b[7:4]};
            ext_more = (b[7:4] == NibMax);
          end else begin
            sat_rem = sat_add(remaining, {24'd0, b});
          end
          remaining_next = sat_rem;
          if (ext_more) begin
            if (lst) begin fail = 1'b1; fcode = ERR_LITLEN; end
            else phase_next = PH_LITEXT;
          end else begin
            lit_sum = {1'b0, produced} + {1'b0, sat_rem};
            if (lit_sum > {1'b0, max_output_size}) begin
              fail = 1'b1; fcode = ERR_LITOVR;
            end else if (sat_rem != 32'd0) begin
              if (lst) begin fail = 1'b1; fcode = ERR_LITOVR; end
              else phase_next = PH_LIT;
            end else if (lst) end_blk = 1'b1;
            else phase_next = PH_OFFLO;
          end
        end
        PH_LIT: begin
          remaining_next = remaining - 32'd1;
          if (remaining_next != 32'd0 && lst) begin
            fail = 1'b1; fcode = ERR_LITOVR;
          end else begin
            c.emit = 1'b1;
            c.lit_byte = b;
            c.wr_addr = AW'(produced);
            c.byte_valid = 1'b1;
            produced_next = produced + 32'd1;
            c.decoded_length = produced_next;
            if (remaining_next == 32'd0) begin
              if (lst) end_blk = 1'b1;
              else phase_next = PH_OFFLO;
            end
          end
        end
        PH_OFFLO: begin
          if (lst) begin fail = 1'b1; fcode = ERR_OFFTRUNC; end
          else begin
            offset_value_next = {8'd0, b};
            phase_next = PH_OFFHI;
          end
        end
        PH_OFFHI, PH_MLEXT: begin
          if (phase == PH_OFFHI) begin
            offset_value_next = {b, offset_value[7:0]};
            rem_in = {28'd0, match_nibble};
            ext_more = (match_nibble == NibMax);
          end else begin
            rem_in = sat_add(remaining, {24'd0, b});
          end
          remaining_next = rem_in;
          if (phase == PH_OFFHI && offset_value_next == 16'd0) begin
            fail = 1'b1; fcode = ERR_ZEROOFF;
          end else if (ext_more) begin
            if (lst) begin fail = 1'b1; fcode = ERR_MLTRUNC; end
            else phase_next = PH_MLEXT;
          end else begin
            sat_rem4 = sat_add(rem_in, 32'(MinMatch));
            remaining_next = sat_rem4;
            ml_sum = {1'b0, produced} + {1'b0, sat_rem4};
            if (32'(offset_value_next) > produced) begin
              fail = 1'b1; fcode = ERR_OFFSTART;
            end else if (ml_sum > {1'b0, max_output_size}) begin
              fail = 1'b1; fcode = ERR_OVERFLOW;
            end else begin
              phase_next = PH_MATCH;
              seen_last_next = lst;
            end
          end
        end
        PH_MATCH: begin fail = 1'b1; fcode = ERR_DURMATCH; end
        default: phase_next = PH_TOKEN;
      endcase
    end
    if (end_blk) begin
      c.emit = 1'b1;
      c.done_res = 1'b1;
      c.match_pending = 1'b0;
      c.decoded_length = produced_next;
    end
    if (fail) begin
      c = '0;
      c.emit = 1'b1;
      c.done_res = 1'b1;
      c.error_code = fcode;
      c.decoded_length = produced;
      discarding_next = !lst;
    end
    if (end_blk || fail) begin
      phase_next = PH_TOKEN;
      remaining_next = '0;
      offset_value_next = '0;
      match_nibble_next = '0;
      produced_next = '0;
      seen_last_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_TOKEN;
      match_nibble <= '0;
      remaining <= '0;
      offset_value <= '0;
      produced <= '0;
      seen_last <= 1'b0;
      discarding <= 1'b0;
      cmd_valid <= 1'b0;
    end else begin
      if (fire && c.emit) cmd_valid <= 1'b1;
      else if (cmd_ready) cmd_valid <= 1'b0;
      if (fire) begin
        phase <= phase_next;
        match_nibble <= match_nibble_next;
        remaining <= remaining_next;
        offset_value <= offset_value_next;
        produced <= produced_next;
        seen_last <= seen_last_next;
        discarding <= discarding_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && c.emit) cmd <= c;
  end
endmodule
`default_nettype wire

// File: hw/rtl/lz4d_back.sv
// Back end: history memory access, match byte forwarding, output register.
`timescale 1ns / 1ps
`default_nettype none
module lz4d_back
  import lz4d_pkg::*;
#(
  parameter int unsigned WINDOW_BYTES = WindowBytes
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  output logic      cmd_ready,
  input  wire cmd_t cmd,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_item_t out_item
);
  localparam int unsigned AW = $clog2(WINDOW_BYTES);

  // Stage 1 reads history and resolves the byte; stage 2 is the output register.
  logic        s_valid;
  cmd_t        s_cmd;
  logic [7:0]  rdata;
  logic        fwd;        // read address equals the previous write
  logic [7:0]  last_wbyte;
  logic        s_ready;
  logic [7:0]  s_byte;
  logic        we;
  logic [7:0]  wdata;

  assign s_ready = !out_valid || out_ready;
  assign cmd_ready = !s_valid || s_ready;
  wire take = cmd_valid && cmd_ready;

  // The byte of stage 1 is final only when stage 1 fires; writes occur then.
  assign s_byte = s_cmd.from_hist ? (fwd ? last_wbyte : rdata) : s_cmd.lit_byte;
  wire s_fire = s_valid && s_ready;
  assign we = s_fire && s_cmd.byte_valid;
  assign wdata = s_byte;

  lz4d_ram #(.WIDTH(8), .DEPTH(WINDOW_BYTES)) u_hist (
    .clk(clk), .we(we), .waddr(s_cmd.wr_addr[AW-1:0]), .wdata(wdata),
    .re(take), .raddr(cmd.src_addr[AW-1:0]), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_ready) out_valid <= s_valid;
      if (cmd_ready) s_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s_cmd <= cmd;
      fwd <= we && (s_cmd.wr_addr == cmd.src_addr);
    end
    if (we) last_wbyte <= wdata;
    if (s_fire) begin
      out_item.byte_valid <= s_cmd.byte_valid;
      out_item.out_byte <= s_cmd.byte_valid ? s_byte : 8'd0;
      out_item.match_pending <= s_cmd.match_pending;
      out_item.done_res <= s_cmd.done_res;
      out_item.error_code <= s_cmd.error_code;
      out_item.decoded_length <= s_cmd.decoded_length;
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/lz4_block_decompressor_top.sv
// Top level: LZ4 block decompressor, parser front end and history back end.
//   channel  dir  handshake             payload
//   in       in   in_valid/in_ready     in_item (in_item_t)
//   out      out  out_valid/out_ready   out_item (out_item_t)
//   cfg      in   cfg_we                cfg_data (max_output_size)
// One transaction per cycle sustained while the output is not stalled; a result
// passes the command register, the history read and the output register in turn.
// Match bytes read the single-port-read history RAM; the previous write is
// forwarded when offset is 1. Synchronous reset; history is not cleared.
// Each stage stalls independently on the next one's ready.
`timescale 1ns / 1ps
`default_nettype none
module lz4_block_decompressor_top
  import lz4d_pkg::*;
#(
  parameter int unsigned WINDOW_BYTES = WindowBytes
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_item,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_item,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_data
);
  logic [31:0] max_output_size;
  logic        cmd_valid, cmd_ready;
  cmd_t        cmd;

  always_ff @(posedge clk) begin
    if (rst) max_output_size <= 32'hFFFF_FFFF;
    else if (cfg_we) max_output_size <= cfg_data;
  end

  lz4d_front #(.WINDOW_BYTES(WINDOW_BYTES)) u_front (
    .clk(clk), .rst(rst), .max_output_size(max_output_size),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
  );

  lz4d_back #(.WINDOW_BYTES(WINDOW_BYTES)) u_back (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
    .cmd(cmd), .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  a_err_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.error_code != ERR_OK |-> out_item.done_res && !out_item.byte_valid)
    else $error("error without done");
  a_pend: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.match_pending |-> !out_item.done_res)
    else $error("pending with done");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd))
    else $error("queue entry changed");
endmodule
`default_nettype wire
